[rtl/band_compositor_mirrored_assert.svh]
// Assertion macros for the band compositor RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef BAND_COMPOSITOR_MIRRORED_ASSERT_SVH
`define BAND_COMPOSITOR_MIRRORED_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, held off while reset is high.
`define BCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also applies during reset.
`define BCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCM_ASSERT(label, prop, msg)
`define BCM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/bcm_pkg.sv]
// Shared constants, codes and port structs of the band compositor.
// No dependencies; imported by bcm_ram and band_compositor_mirrored.
package bcm_pkg;

  localparam int SCREEN_COLS = 320;
  localparam int BAND_ROWS   = 16;
  localparam int STORE_DEPTH = SCREEN_COLS * BAND_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(BAND_ROWS + 1);
  localparam int COL_W       = $clog2(SCREEN_COLS + 1);

  localparam int POS_W       = 11;
  localparam int DIM_W       = 10;
  localparam int PIX_W       = 16;
  localparam int OUT_ROW_W   = 4;
  localparam int OUT_COL_W   = 9;
  localparam int CALC_W      = 14;

  localparam logic [PIX_W-1:0] BLACK = 16'h0000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RECT  = 2'd1,
    OP_ICON  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

[rtl/bcm_ram.sv]
// Band store: single-port-write, single-port-read synchronous RAM.
// Depends on bcm_pkg for depth, widths and request structs.
module bcm_ram import bcm_pkg::*; (
  input  logic             clk,
  input  wr_req_t          wr,
  input  rd_req_t          rd,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[rtl/band_compositor_mirrored.sv]
// Top level of the band compositor: item sequencer, clip logic, fill walker.
// Depends on bcm_pkg, bcm_ram and band_compositor_mirrored_assert.svh.
//
//   channel | dir | handshake                   | word
//   --------+-----+-----------------------------+-------------------------------------------
//   item    | in  | item_valid / item_ready     | op through src_row, ten fields, port order
//   result  | out | result_valid / result_ready | pixel, pixel_row, pixel_col
//
// A read may wait for the result register; a fill rectangle walks its clipped area and
// a start band all SCREEN_COLS*BAND_ROWS entries through the one write port of the band
// store, one pixel a cycle.
// Reset: a clearing pass over the whole band runs first with item_ready low; band_top
// resets to zero.
// Stalls: a held result blocks only the next read, which waits in READ with item_ready low.
`include "band_compositor_mirrored_assert.svh"

module band_compositor_mirrored import bcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [1:0]              op,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [DIM_W-1:0]        width,
  input  logic [DIM_W-1:0]        height,
  input  logic [PIX_W-1:0]        color,
  input  logic [PIX_W-1:0]        transparent_key,
  input  logic [1:0]              rotation,
  input  logic [DIM_W-1:0]        src_col,
  input  logic [DIM_W-1:0]        src_row,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [PIX_W-1:0]        pixel,
  output logic [OUT_ROW_W-1:0]    pixel_row,
  output logic [OUT_COL_W-1:0]    pixel_col
);

  // One-hot sequencer: IDLE takes a word, CALC clips/places it, then FILL walks
  // the store, WRITE stores one icon pixel, or READ hands the RAM data out.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CALC  = 5'b00010,
    ST_FILL  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  localparam logic signed [CALC_W-1:0] COLS_S = CALC_W'(SCREEN_COLS);
  localparam logic signed [CALC_W-1:0] ROWS_S = CALC_W'(BAND_ROWS);

  // Store index of screen column scol on band row row, mirrored left to right.
  function automatic logic [ADDR_W-1:0] mirror_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] scol);
    logic [ADDR_W-1:0] mcol;
    mcol = ADDR_W'(SCREEN_COLS - 1) - ADDR_W'(scol);
    return ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + mcol;
  endfunction

  function automatic logic signed [CALC_W-1:0] ext_pos(input logic [POS_W-1:0] v);
    return $signed({{(CALC_W-POS_W){v[POS_W-1]}}, v});
  endfunction

  function automatic logic signed [CALC_W-1:0] ext_dim(input logic [DIM_W-1:0] v);
    return $signed({{(CALC_W-DIM_W){1'b0}}, v});
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [CALC_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v[CALC_W-1]) begin
      r = '0;
    end else if (v > ROWS_S) begin
      r = ROW_W'(BAND_ROWS);
    end else begin
      r = v[ROW_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [CALC_W-1:0] v);
    logic [COL_W-1:0] c;
    if (v[CALC_W-1]) begin
      c = '0;
    end else if (v > COLS_S) begin
      c = COL_W'(SCREEN_COLS);
    end else begin
      c = v[COL_W-1:0];
    end
    return c;
  endfunction

  state_t state;

  // Captured item word.
  op_t              op_q;
  logic [POS_W-1:0] x_q;
  logic [POS_W-1:0] y_q;
  logic [DIM_W-1:0] w_q;
  logic [DIM_W-1:0] h_q;
  logic [PIX_W-1:0] color_q;
  logic [PIX_W-1:0] key_q;
  rot_t             rot_q;
  logic [DIM_W-1:0] col_q;
  logic [DIM_W-1:0] row_q;

  logic [POS_W-1:0] band_top;

  // Fill walker: current position, clipped bounds, fill value.
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] r1;
  logic [COL_W-1:0] c0;
  logic [COL_W-1:0] c1;
  logic [PIX_W-1:0] fill_color;
  logic             fill_live;

  // Placed icon pixel, in screen column and band row.
  logic signed [CALC_W-1:0] sx_q;
  logic signed [CALC_W-1:0] by_q;
  logic                     skip_q;
  logic                     icon_hit;

  // CALC outputs.
  logic signed [CALC_W-1:0] ox;
  logic signed [CALC_W-1:0] oy;
  logic signed [CALC_W-1:0] sx_next;
  logic signed [CALC_W-1:0] by_next;
  logic                     read_ok;

  wr_req_t          wr;
  rd_req_t          rd;
  logic [PIX_W-1:0] rd_data;

  bcm_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign item_ready = (state == ST_IDLE);
  assign fill_live  = (row < r1) && (c0 < c1);
  assign icon_hit   = !skip_q && !sx_q[CALC_W-1] && (sx_q < COLS_S)
                      && !by_q[CALC_W-1] && (by_q < ROWS_S);

  // Rotate the source position inside the icon, then place it and move to
  // band-relative rows.
  always_comb begin
    case (rot_q)
      ROT_90: begin
        ox = ext_dim(h_q) - CALC_W'(1) - ext_dim(row_q);
        oy = ext_dim(col_q);
      end
      ROT_180: begin
        ox = ext_dim(w_q) - CALC_W'(1) - ext_dim(col_q);
        oy = ext_dim(h_q) - CALC_W'(1) - ext_dim(row_q);
      end
      ROT_270: begin
        ox = ext_dim(row_q);
        oy = ext_dim(w_q) - CALC_W'(1) - ext_dim(col_q);
      end
      default: begin
        ox = ext_dim(col_q);
        oy = ext_dim(row_q);
      end
    endcase
    sx_next = ext_pos(x_q) + ox;
    by_next = ext_pos(y_q) + oy - ext_pos(band_top);
  end

  assign read_ok = ({1'b0, row_q} < (DIM_W+1)'(BAND_ROWS))
                   && ({1'b0, col_q} < (DIM_W+1)'(SCREEN_COLS));

  // Store ports: writes come from the fill walker or the icon stage, reads only
  // from CALC, so a read never meets a write in flight to the same entry.
  always_comb begin
    wr = '0;
    rd = '0;
    case (state)
      ST_FILL: begin
        wr.en   = fill_live;
        wr.addr = mirror_addr(row, col);
        wr.data = fill_color;
      end
      ST_WRITE: begin
        wr.en   = icon_hit;
        wr.addr = mirror_addr(by_q[ROW_W-1:0], sx_q[COL_W-1:0]);
        wr.data = color_q;
      end
      ST_CALC: begin
        rd.en   = (op_q == OP_READ) && read_ok;
        rd.addr = ADDR_W'(row_q[ROW_W-1:0]) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col_q);
      end
      default: begin
      end
    endcase
  end

  // Item capture; payload registers hold no reset.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      op_q    <= op_t'(op);
      x_q     <= pos_x;
      y_q     <= pos_y;
      w_q     <= width;
      h_q     <= height;
      color_q <= color;
      key_q   <= transparent_key;
      rot_q   <= rot_t'(rotation);
      col_q   <= src_col;
      row_q   <= src_row;
    end
    if (state == ST_CALC) begin
      sx_q   <= sx_next;
      by_q   <= by_next;
      skip_q <= (color_q == key_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // Start with a full-band clear so the store reads as black.
      state        <= ST_FILL;
      band_top     <= '0;
      row          <= '0;
      col          <= '0;
      r1           <= ROW_W'(BAND_ROWS);
      c0           <= '0;
      c1           <= COL_W'(SCREEN_COLS);
      fill_color   <= BLACK;
      result_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless READ refills it this cycle.
      if (result_valid && result_ready && (state != ST_READ)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          case (op_q)
            OP_START: begin
              band_top   <= y_q;
              row        <= '0;
              col        <= '0;
              r1         <= ROW_W'(BAND_ROWS);
              c0         <= '0;
              c1         <= COL_W'(SCREEN_COLS);
              fill_color <= BLACK;
              state      <= ST_FILL;
            end
            OP_RECT: begin
              // Clip to band rows and screen columns; an empty box falls
              // straight out of FILL.
              row        <= clamp_row(ext_pos(y_q) - ext_pos(band_top));
              r1         <= clamp_row(ext_pos(y_q) + ext_dim(h_q) - ext_pos(band_top));
              col        <= clamp_col(ext_pos(x_q));
              c0         <= clamp_col(ext_pos(x_q));
              c1         <= clamp_col(ext_pos(x_q) + ext_dim(w_q));
              fill_color <= color_q;
              state      <= ST_FILL;
            end
            OP_ICON: begin
              state <= ST_WRITE;
            end
            default: begin
              // Read: out-of-range positions return nothing.
              state <= read_ok ? ST_READ : ST_IDLE;
            end
          endcase
        end
        ST_FILL: begin
          if (fill_live) begin
            if (col == c1 - COL_W'(1)) begin
              col <= c0;
              row <= row + ROW_W'(1);
            end else begin
              col <= col + COL_W'(1);
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          // Hold the RAM data until the result register frees up.
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_READ) && (!result_valid || result_ready)) begin
      pixel     <= rd_data;
      pixel_row <= row_q[OUT_ROW_W-1:0];
      pixel_col <= col_q[OUT_COL_W-1:0];
    end
  end

  `BCM_ASSERT(a_wr_in_range, wr.en |-> (wr.addr < ADDR_W'(STORE_DEPTH)), "store write out of range")
  `BCM_ASSERT(a_no_rd_wr_clash, !(wr.en && rd.en), "store read and write in the same cycle")
  `BCM_ASSERT(a_result_from_read, $rose(result_valid) |-> $past(state == ST_READ), "stray result")
  `BCM_ASSERT(a_fill_clipped, (state == ST_FILL && wr.en) |-> (row < r1 && col < c1), "fill off box")
  `BCM_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (state == ST_FILL), "no clear after reset")

endmodule
